### rtl/core/keyed_fifo_with_cancel_macros.svh
// Assertion helpers used by the RTL.
`ifndef KEYED_FIFO_WITH_CANCEL_MACROS_SVH
`define KEYED_FIFO_WITH_CANCEL_MACROS_SVH

// Same-cycle implication.
`define KFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyed fifo: same-cycle check failed");

// Next-cycle implication.
`define KFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyed fifo: next-cycle check failed");

`endif

### rtl/core/kfifo_pkg.sv
package kfifo_pkg;

	localparam int DEPTH  = 16;
	localparam int FILL_W = $clog2(DEPTH + 1);

	localparam int CMD_W  = 2;
	localparam int ID_W   = 32;
	localparam int CUST_W = 32;
	localparam int COST_W = 24;
	localparam int CNT_W  = 5;
	localparam int STAT_W = 3;

	localparam int IN_DATA_W  = ((ID_W + CUST_W + COST_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ID_W + CUST_W + COST_W + 7) / 8) * 8;
	localparam int OUT_USER_W = STAT_W + 1;
	localparam int CMP_W      = (FILL_W > CNT_W) ? FILL_W : CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT,
		CMD_UPDATE,
		CMD_CANCEL,
		CMD_PROCESS
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED,
		STAT_UPDATED,
		STAT_NOT_FOUND,
		STAT_EMPTY,
		STAT_FULL,
		STAT_POPPED,
		STAT_NONE
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_POP
	} fsm_t;

	typedef struct packed {
		logic [ID_W-1:0]   order_id;
		logic [CUST_W-1:0] customer_no;
		logic [COST_W-1:0] cost_cents;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic upd;
	} cell_ctrl_t;

	typedef struct packed {
		status_t status;
		logic    ran_out;
		logic    last;
		entry_t  ent;
	} result_t;

endpackage

### rtl/core/kfifo_cell.sv
module kfifo_cell (
	input  logic                              clk,
	input  kfifo_pkg::cell_ctrl_t             ctrl,
	input  logic                              occ,
	input  logic [kfifo_pkg::ID_W-1:0]        key,
	input  logic [kfifo_pkg::CUST_W-1:0]      cust_in,
	input  logic [kfifo_pkg::COST_W-1:0]      cost_in,
	input  kfifo_pkg::entry_t                 next_ent,
	output kfifo_pkg::entry_t                 ent,
	output logic                              hit
);

	kfifo_pkg::entry_t ent_q;

	// shift takes the neighbor toward the tail; load appends; upd rewrites payload
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			ent_q <= next_ent;
		end else if (ctrl.load) begin
			ent_q.order_id    <= key;
			ent_q.customer_no <= cust_in;
			ent_q.cost_cents  <= cost_in;
		end else if (ctrl.upd) begin
			ent_q.customer_no <= cust_in;
			ent_q.cost_cents  <= cost_in;
		end
	end

	assign ent = ent_q;
	assign hit = occ && (ent_q.order_id == key);

endmodule

### rtl/core/keyed_fifo_with_cancel.sv
// Insert, update-only and cancel: result registered in the cycle after the transaction is
// accepted; one such command per cycle while the output is taken.
// Process popping n entries: after accept, results come one per cycle while the output is
// taken, as the cells shift the head out per pop; no input is taken until the last pop.
// Reset (arst_n low) empties the queue and clears the output; entry storage is not cleared.
`include "keyed_fifo_with_cancel_macros.svh"

module keyed_fifo_with_cancel (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// order_id, customer_no, cost_cents, count, zero pad
	input  logic [kfifo_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic [kfifo_pkg::CMD_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_order_id, out_customer_no, out_cost_cents, zero pad
	output logic [kfifo_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status, ran_out
	output logic [kfifo_pkg::OUT_USER_W-1:0]     m_tuser,
	output logic                                 m_tlast
);

	localparam int DEPTH  = kfifo_pkg::DEPTH;
	localparam int FILL_W = kfifo_pkg::FILL_W;
	localparam int ID_W   = kfifo_pkg::ID_W;
	localparam int CUST_W = kfifo_pkg::CUST_W;
	localparam int COST_W = kfifo_pkg::COST_W;
	localparam int CNT_W  = kfifo_pkg::CNT_W;
	localparam int CMP_W  = kfifo_pkg::CMP_W;

	kfifo_pkg::fsm_t    fsm_q, fsm_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [FILL_W-1:0]  rem_q, rem_d;
	logic               ro_q, ro_d;
	logic               out_vld_q;
	kfifo_pkg::result_t out_q, out_d;
	logic               out_load;
	logic               out_free;
	logic               accept;
	logic               pop_go;

	kfifo_pkg::cmd_t    in_cmd;
	logic [ID_W-1:0]    in_id;
	logic [CUST_W-1:0]  in_cust;
	logic [COST_W-1:0]  in_cost;
	logic [CNT_W-1:0]   in_cnt;

	kfifo_pkg::entry_t     ents [DEPTH];
	kfifo_pkg::cell_ctrl_t ctrl [DEPTH];
	logic [DEPTH-1:0]      hit;
	logic [DEPTH-1:0]      occ;
	logic [DEPTH-1:0]      first_hit;
	logic [DEPTH-1:0]      rm_mask;
	logic [DEPTH-1:0]      tail_sel;
	logic [DEPTH-1:0]      shift_v, load_v, upd_v;
	kfifo_pkg::entry_t     sel_ent;
	logic                  any_hit;
	logic                  is_full;
	logic                  is_empty;

	assign in_cmd  = kfifo_pkg::cmd_t'(s_tuser);
	assign in_id   = s_tdata[ID_W-1:0];
	assign in_cust = s_tdata[ID_W +: CUST_W];
	assign in_cost = s_tdata[ID_W+CUST_W +: COST_W];
	assign in_cnt  = s_tdata[ID_W+CUST_W+COST_W +: CNT_W];

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (fsm_q == kfifo_pkg::FSM_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign pop_go   = (fsm_q == kfifo_pkg::FSM_POP) && out_free;

	assign is_full  = (fill_q == FILL_W'(DEPTH));
	assign is_empty = (fill_q == '0);
	assign any_hit  = |hit;

	// lowest matching slot, and every slot from it toward the tail
	assign first_hit = hit & (~hit + 1'b1);
	assign rm_mask   = ~(first_hit - 1'b1);

	always_comb begin
		sel_ent = '0;
		for (int i = 0; i < DEPTH; i++) begin
			occ[i]      = (FILL_W'(i) < fill_q);
			tail_sel[i] = (fill_q == FILL_W'(i));
			if (first_hit[i]) begin
				sel_ent = sel_ent | ents[i];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		kfifo_pkg::entry_t nxt;

		if (g == DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ents[g+1];
		end

		assign ctrl[g].shift = shift_v[g];
		assign ctrl[g].load  = load_v[g];
		assign ctrl[g].upd   = upd_v[g];

		kfifo_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl[g]),
			.occ      (occ[g]),
			.key      (in_id),
			.cust_in  (in_cust),
			.cost_in  (in_cost),
			.next_ent (nxt),
			.ent      (ents[g]),
			.hit      (hit[g])
		);
	end

	always_comb begin
		fsm_d    = fsm_q;
		fill_d   = fill_q;
		rem_d    = rem_q;
		ro_d     = ro_q;
		shift_v  = '0;
		load_v   = '0;
		upd_v    = '0;
		out_load = 1'b0;
		out_d         = '0;
		out_d.status  = kfifo_pkg::STAT_NONE;
		out_d.last    = 1'b1;

		unique case (fsm_q)
			kfifo_pkg::FSM_IDLE: begin
				if (accept) begin
					unique case (in_cmd) inside
						kfifo_pkg::CMD_INSERT, kfifo_pkg::CMD_UPDATE: begin
							out_load = 1'b1;
							if (any_hit) begin
								upd_v        = first_hit;
								out_d.status = kfifo_pkg::STAT_UPDATED;
							end else if (in_cmd == kfifo_pkg::CMD_UPDATE) begin
								out_d.status = kfifo_pkg::STAT_NOT_FOUND;
							end else if (is_full) begin
								out_d.status = kfifo_pkg::STAT_FULL;
							end else begin
								load_v       = tail_sel;
								fill_d       = fill_q + 1'b1;
								out_d.status = kfifo_pkg::STAT_INSERTED;
							end
						end
						kfifo_pkg::CMD_CANCEL: begin
							out_load = 1'b1;
							if (is_empty) begin
								out_d.status = kfifo_pkg::STAT_EMPTY;
							end else if (!any_hit) begin
								out_d.status = kfifo_pkg::STAT_NOT_FOUND;
							end else begin
								shift_v      = rm_mask;
								fill_d       = fill_q - 1'b1;
								out_d.status = kfifo_pkg::STAT_POPPED;
								out_d.ent    = sel_ent;
							end
						end
						kfifo_pkg::CMD_PROCESS: begin
							if (is_empty) begin
								out_load     = 1'b1;
								out_d.status = kfifo_pkg::STAT_EMPTY;
							end else if (in_cnt == '0) begin
								out_load     = 1'b1;
								out_d.status = kfifo_pkg::STAT_NONE;
							end else begin
								fsm_d = kfifo_pkg::FSM_POP;
								ro_d  = (CMP_W'(in_cnt) > CMP_W'(fill_q));
								rem_d = ro_d ? fill_q : FILL_W'(in_cnt);
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			kfifo_pkg::FSM_POP: begin
				if (pop_go) begin
					shift_v       = '1;
					fill_d        = fill_q - 1'b1;
					rem_d         = rem_q - 1'b1;
					out_load      = 1'b1;
					out_d.status  = kfifo_pkg::STAT_POPPED;
					out_d.ent     = ents[0];
					out_d.ran_out = ro_q;
					out_d.last    = (rem_q == FILL_W'(1));
					if (rem_q == FILL_W'(1)) begin
						fsm_d = kfifo_pkg::FSM_IDLE;
					end
				end
			end
			default: begin
				fsm_d = kfifo_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= kfifo_pkg::FSM_IDLE;
			fill_q    <= '0;
			rem_q     <= '0;
			ro_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			fsm_q  <= fsm_d;
			fill_q <= fill_d;
			rem_q  <= rem_d;
			ro_q   <= ro_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = kfifo_pkg::OUT_DATA_W'({out_q.ent.cost_cents, out_q.ent.customer_no,
		out_q.ent.order_id});
	assign m_tuser  = {out_q.ran_out, out_q.status};
	assign m_tlast  = out_q.last;

	`KFC_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(DEPTH))
	`KFC_ASSERT_IMP(a_pop_nonempty, clk, arst_n, fsm_q == kfifo_pkg::FSM_POP,
		(fill_q != '0) && (rem_q != '0) && (rem_q <= fill_q))
	`KFC_ASSERT_NXT(a_pop_drains, clk, arst_n, pop_go, fill_q == $past(fill_q) - 1'b1)
	`KFC_ASSERT_IMP(a_single_last, clk, arst_n,
		out_vld_q && (out_q.status != kfifo_pkg::STAT_POPPED), out_q.last && !out_q.ran_out)
	`KFC_ASSERT_IMP(a_hit_onehot, clk, arst_n, 1'b1, $onehot0(first_hit) && ((hit & ~occ) == '0))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH      = kfifo_pkg::DEPTH;
	localparam int ID_W       = kfifo_pkg::ID_W;
	localparam int CUST_W     = kfifo_pkg::CUST_W;
	localparam int COST_W     = kfifo_pkg::COST_W;
	localparam int CNT_W      = kfifo_pkg::CNT_W;
	localparam int STAT_W     = kfifo_pkg::STAT_W;
	localparam int CMD_W      = kfifo_pkg::CMD_W;
	localparam int IN_DATA_W  = kfifo_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = kfifo_pkg::OUT_DATA_W;
	localparam int OUT_USER_W = kfifo_pkg::OUT_USER_W;

	localparam int CUST_LO  = ID_W;
	localparam int COST_LO  = ID_W + CUST_W;
	localparam int CNT_LO   = ID_W + CUST_W + COST_W;
	localparam int N_RANDOM = 350;
	localparam int HOLD_AT  = 60;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_AT = 200;
	localparam int ID_POOL  = 20;

	typedef struct {
		kfifo_pkg::cmd_t   cmd;
		logic [ID_W-1:0]   order_id;
		logic [CUST_W-1:0] customer_no;
		logic [COST_W-1:0] cost_cents;
		logic [CNT_W-1:0]  count;
		int                gap;
		bit                drain;
	} order_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	order_cmd_t           order_cmds[$];
	kfifo_pkg::result_t   due_results[$];
	kfifo_pkg::entry_t    book[DEPTH];
	int                   book_fill;

	order_cmd_t          cur_cmd;
	logic [IN_DATA_W-1:0] pkt;
	int  gap_left;
	int  sent_cnt;
	int  exp_total;
	int  rx_total;
	int  stall_left;
	int  hold_left;
	bit  hold_done;
	bit  rx_fast;
	bit  tx_fast;
	int  rx_gap;
	int  n_res;
	int  errors;
	logic [ID_W-1:0] id_pool[ID_POOL];
	logic [ID_W-1:0] dir_ids[DEPTH];

	keyed_fifo_with_cancel uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void post(kfifo_pkg::status_t st, kfifo_pkg::entry_t e, bit ro, bit lst);
		kfifo_pkg::result_t r;
		r.status  = st;
		r.ran_out = ro;
		r.last    = lst;
		r.ent     = e;
		due_results.push_back(r);
	endfunction

	function automatic int find_order(logic [ID_W-1:0] id);
		for (int i = 0; i < book_fill; i++) begin
			if (book[i].order_id == id)
				return i;
		end
		return -1;
	endfunction

	function automatic void remove_slot(int idx);
		for (int j = idx; j + 1 < book_fill; j++)
			book[j] = book[j + 1];
		book_fill--;
	endfunction

	// Returns the number of results the command produces.
	function automatic int book_order_cmd(order_cmd_t t);
		int                m;
		int                n;
		bit                ro;
		kfifo_pkg::entry_t blank;
		blank = '0;
		if (t.cmd == kfifo_pkg::CMD_INSERT || t.cmd == kfifo_pkg::CMD_UPDATE) begin
			m = find_order(t.order_id);
			if (m >= 0) begin
				book[m].customer_no = t.customer_no;
				book[m].cost_cents  = t.cost_cents;
				post(kfifo_pkg::STAT_UPDATED, blank, 1'b0, 1'b1);
			end else if (t.cmd == kfifo_pkg::CMD_UPDATE) begin
				post(kfifo_pkg::STAT_NOT_FOUND, blank, 1'b0, 1'b1);
			end else if (book_fill >= DEPTH) begin
				post(kfifo_pkg::STAT_FULL, blank, 1'b0, 1'b1);
			end else begin
				book[book_fill].order_id    = t.order_id;
				book[book_fill].customer_no = t.customer_no;
				book[book_fill].cost_cents  = t.cost_cents;
				book_fill++;
				post(kfifo_pkg::STAT_INSERTED, blank, 1'b0, 1'b1);
			end
			return 1;
		end
		if (t.cmd == kfifo_pkg::CMD_CANCEL) begin
			if (book_fill == 0) begin
				post(kfifo_pkg::STAT_EMPTY, blank, 1'b0, 1'b1);
				return 1;
			end
			m = find_order(t.order_id);
			if (m < 0) begin
				post(kfifo_pkg::STAT_NOT_FOUND, blank, 1'b0, 1'b1);
				return 1;
			end
			post(kfifo_pkg::STAT_POPPED, book[m], 1'b0, 1'b1);
			remove_slot(m);
			return 1;
		end
		if (book_fill == 0) begin
			post(kfifo_pkg::STAT_EMPTY, blank, 1'b0, 1'b1);
			return 1;
		end
		if (t.count == 0) begin
			post(kfifo_pkg::STAT_NONE, blank, 1'b0, 1'b1);
			return 1;
		end
		ro = (int'(t.count) > book_fill);
		n  = ro ? book_fill : int'(t.count);
		for (int k = 0; k < n; k++) begin
			post(kfifo_pkg::STAT_POPPED, book[0], ro, k == n - 1);
			remove_slot(0);
		end
		return n;
	endfunction

	task automatic add_cmd(kfifo_pkg::cmd_t c, logic [ID_W-1:0] id, logic [CUST_W-1:0] cu,
	                       logic [COST_W-1:0] co, logic [CNT_W-1:0] cnt);
		order_cmd_t t;
		if ($urandom_range(0, 29) == 0)
			tx_fast = !tx_fast;
		t.cmd         = c;
		t.order_id    = id;
		t.customer_no = cu;
		t.cost_cents  = co;
		t.count       = cnt;
		t.gap         = tx_fast ? 0 : $urandom_range(0, 13);
		t.drain       = 1'b0;
		order_cmds.push_back(t);
	endtask

	task automatic build_stimulus();
		int               r;
		int               q;
		kfifo_pkg::cmd_t  c;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] cnt;
		for (int i = 0; i < DEPTH; i++)
			dir_ids[i] = $urandom;
		dir_ids[0] = '0;
		dir_ids[1] = '1;
		for (int i = 0; i < ID_POOL; i++)
			id_pool[i] = $urandom;
		id_pool[0] = '0;
		id_pool[1] = '1;

		// empty queue
		add_cmd(kfifo_pkg::CMD_PROCESS, $urandom, $urandom, COST_W'($urandom), 5'd16);
		add_cmd(kfifo_pkg::CMD_CANCEL, dir_ids[0], $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_UPDATE, dir_ids[1], $urandom, COST_W'($urandom), 5'd3);
		// fill to capacity, field extremes first
		add_cmd(kfifo_pkg::CMD_INSERT, dir_ids[0], '0, '0, '0);
		add_cmd(kfifo_pkg::CMD_INSERT, dir_ids[1], '1, '1, 5'd15);
		for (int i = 2; i < DEPTH; i++)
			add_cmd(kfifo_pkg::CMD_INSERT, dir_ids[i], $urandom, COST_W'($urandom),
			        CNT_W'($urandom));
		add_cmd(kfifo_pkg::CMD_INSERT, 32'h5a5a_0001, $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_INSERT, dir_ids[0], '1, '1, 5'd0);
		add_cmd(kfifo_pkg::CMD_UPDATE, dir_ids[1], '0, '0, 5'd0);
		add_cmd(kfifo_pkg::CMD_UPDATE, 32'h5a5a_0002, $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_CANCEL, 32'h5a5a_0003, $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_CANCEL, dir_ids[7], $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_PROCESS, $urandom, $urandom, COST_W'($urandom), 5'd0);
		add_cmd(kfifo_pkg::CMD_PROCESS, $urandom, $urandom, COST_W'($urandom), 5'd16);

		for (int i = 0; i < N_RANDOM; i++) begin
			r   = $urandom_range(0, 99);
			id  = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, ID_POOL - 1)];
			q   = $urandom_range(0, 9);
			cnt = (q == 0) ? 5'd0 : (q == 1) ? 5'd16 : 5'($urandom_range(1, 6));
			if (i >= 120 && i < 140)
				c = kfifo_pkg::CMD_INSERT;
			else if (r < 45)
				c = kfifo_pkg::CMD_INSERT;
			else if (r < 60)
				c = kfifo_pkg::CMD_UPDATE;
			else if (r < 75)
				c = kfifo_pkg::CMD_CANCEL;
			else if (r < 92)
				c = kfifo_pkg::CMD_PROCESS;
			else begin
				c   = kfifo_pkg::cmd_t'($urandom_range(0, 3));
				id  = $urandom;
				cnt = 5'($urandom_range(0, 16));
			end
			if (i >= 120 && i < 140)
				id = $urandom;
			add_cmd(c, id, $urandom, COST_W'($urandom), cnt);
		end
		order_cmds[DRAIN_AT].drain = 1'b1;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tuser   <= '0;
			gap_left  <= 0;
			sent_cnt  <= 0;
			exp_total <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				n_res = book_order_cmd(cur_cmd);
				sent_cnt  <= sent_cnt + 1;
				exp_total <= exp_total + n_res;
			end
			if (s_tvalid && !s_tready) begin
				// hold the transaction
			end else if (s_tvalid && cur_cmd.gap != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= cur_cmd.gap - 1;
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (order_cmds.size() != 0 &&
			             (!order_cmds[0].drain || (!s_tvalid && exp_total == rx_total))) begin
				cur_cmd = order_cmds.pop_front();
				pkt = '0;
				pkt[CUST_LO-1:0]        = cur_cmd.order_id;
				pkt[COST_LO-1:CUST_LO]  = cur_cmd.customer_no;
				pkt[CNT_LO-1:COST_LO]   = cur_cmd.cost_cents;
				pkt[CNT_LO+CNT_W-1:CNT_LO] = cur_cmd.count;
				s_tdata  <= pkt;
				s_tuser  <= cur_cmd.cmd;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_total   <= 0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_total <= rx_total + 1;
				if (due_results.size() == 0) begin
					$error("unexpected result transaction, status %0d", m_tuser[STAT_W-1:0]);
					errors++;
				end else begin
					kfifo_pkg::result_t e;
					e = due_results.pop_front();
					check_field("status", 64'(e.status), 64'(m_tuser[STAT_W-1:0]));
					check_field("out_order_id", 64'(e.ent.order_id),
					            64'(m_tdata[CUST_LO-1:0]));
					check_field("out_customer_no", 64'(e.ent.customer_no),
					            64'(m_tdata[COST_LO-1:CUST_LO]));
					check_field("out_cost_cents", 64'(e.ent.cost_cents),
					            64'(m_tdata[CNT_LO-1:COST_LO]));
					check_field("ran_out", 64'(e.ran_out), 64'(m_tuser[STAT_W]));
					check_field("last", 64'(e.last), 64'(m_tlast));
				end
			end
			if (hold_left != 0) begin
				m_tready  <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && sent_cnt == HOLD_AT) begin
				m_tready  <= 1'b0;
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
			end else if (m_tvalid && m_tready) begin
				if ($urandom_range(0, 29) == 0)
					rx_fast = !rx_fast;
				rx_gap = rx_fast ? 0 : $urandom_range(0, 13);
				if (rx_gap == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready   <= 1'b0;
					stall_left <= rx_gap - 1;
				end
			end else if (stall_left != 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		errors    = 0;
		book_fill = 0;
		tx_fast   = 1'b0;
		rx_fast   = 1'b0;
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (order_cmds.size() != 0 || s_tvalid || exp_total != rx_total)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d expected results never arrived", due_results.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
